FILE: sv/wrapped_kernel_convolution_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the wrapped kernel convolution block
// Property wrappers sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef WRAPPED_KERNEL_CONVOLUTION_DEFINES_SVH
`define WRAPPED_KERNEL_CONVOLUTION_DEFINES_SVH

// same-cycle implication
`define WKC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/wkc_pkg.sv
// ---------------------------------------------------------------------------
// wkc_pkg
// Shared constants, types and sequencer states for the convolution block.
// ---------------------------------------------------------------------------
`default_nettype none

package wkc_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_KERNEL = 7;
  localparam int NCOEF      = MAX_KERNEL * MAX_KERNEL;
  localparam int CIDX_W     = $clog2(NCOEF);
  localparam int COLB       = $clog2(MAX_WIDTH);
  localparam int ROWB       = $clog2(MAX_HEIGHT);
  localparam int FS_AW      = COLB + ROWB;
  localparam int FS_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int UNITY      = 256;

  localparam int DVD_W      = 24;
  localparam int DVS_W      = 22;
  localparam int DCNT_W     = $clog2(DVD_W + 1);

  localparam logic [1:0] FUNC_COEF    = 2'd0;
  localparam logic [1:0] FUNC_PIXEL   = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KSIZE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_SC_RD,
    ST_SC_DIV,
    ST_SC_WAIT,
    ST_MODR,
    ST_MODR_W,
    ST_MODC,
    ST_MODC_W,
    ST_WRAPR,
    ST_WRAPC,
    ST_TAP_RD,
    ST_TAP_MAC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: sv/wkc_div.sv
// ---------------------------------------------------------------------------
// wkc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module wkc_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wkc_pkg::div_req_t req,
  output wkc_pkg::div_rsp_t      rsp
);

  logic [wkc_pkg::DVD_W-1:0]  dvd;
  logic [wkc_pkg::DVS_W-1:0]  dvs;
  logic [wkc_pkg::DVS_W:0]    rem;
  logic [wkc_pkg::DCNT_W-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [wkc_pkg::DVS_W:0]    rem_sh;
  logic                       ge;

  assign rem_sh = {rem[wkc_pkg::DVS_W-1:0], dvd[wkc_pkg::DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= wkc_pkg::DCNT_W'(wkc_pkg::DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == wkc_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[wkc_pkg::DVD_W-2:0], ge};
      rem <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = rem[wkc_pkg::DVS_W-1:0];

endmodule

`default_nettype wire

FILE: sv/wrapped_kernel_convolution.sv
// ---------------------------------------------------------------------------
// wrapped_kernel_convolution
// Grayscale 2D convolution, flipped square kernel, toroidal edges.
// ---------------------------------------------------------------------------
// Coefficient and pixel loads are written to memory as they are accepted. A
// compute transaction runs two passes of the shared divider for the row and
// column wrap, then two reads per tap through the frame and scaled
// coefficient memories. The first compute after a coefficient load or a kernel
// size write first rebuilds the scaled coefficients: it sums the k*k
// coefficients, then scales each of the 49 entries, through the divider when
// the sum exceeds 1.0. Input is refused until the item is done; a finished
// result waits in the output register while the next transaction is taken.
`default_nettype none
`include "wrapped_kernel_convolution_defines.svh"

module wrapped_kernel_convolution (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] pixel_row, [15:8] pixel_col, [21:16] coef_index, [37:22] item_value
  input  wire logic [39:0] s_tdata,
  // [1:0] func
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] pixel_out, [15:8] out_row, [23:16] out_col
  output logic [23:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  wkc_pkg::state_t state, state_next;

  logic [8:0] image_width, image_height;
  logic [2:0] kern_side;
  logic       coef_stale;

  logic [1:0]         func;
  logic [7:0]         in_row, in_col;
  logic [5:0]         in_cidx;
  logic signed [15:0] in_val;
  logic               in_acc;
  logic               coef_ld;

  assign func    = s_tuser;
  assign in_row  = s_tdata[7:0];
  assign in_col  = s_tdata[15:8];
  assign in_cidx = s_tdata[21:16];
  assign in_val  = s_tdata[37:22];

  assign s_tready  = (state == wkc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign coef_ld   = in_acc && func == wkc_pkg::FUNC_COEF && in_cidx < 6'(wkc_pkg::NCOEF);

  // memories
  logic [7:0]  frame_mem [wkc_pkg::FS_DEPTH];
  logic [15:0] coef_mem  [wkc_pkg::NCOEF];
  logic [15:0] scl_mem   [wkc_pkg::NCOEF];
  logic [wkc_pkg::NCOEF-1:0] coef_vld, scl_vld;
  logic [7:0]  frame_rd;
  logic [15:0] coef_rd, scl_rd;
  logic        coef_rd_vld, scl_rd_vld;
  logic signed [15:0] coef_val, scl_val;

  // latched compute item
  logic [7:0] row_q, col_q;
  logic [8:0] w_q, h_q;
  logic [2:0] k_q;
  logic [1:0] half_q;
  logic [5:0] last_q;
  logic [8:0] w_sat, h_sat;
  logic [2:0] k_sat;
  logic [5:0] taps_sat;

  logic [wkc_pkg::CIDX_W-1:0] idx;
  logic signed [21:0] sum;
  logic               neg_q;
  logic signed [9:0]  rr, cc, c_start;
  logic [2:0]         kr, kc;
  logic [7:0]         acc;

  wkc_pkg::div_req_t div_req;
  wkc_pkg::div_rsp_t div_rsp;

  // control outputs
  logic                       coef_rd_en, scl_rd_en, frame_rd_en;
  logic [wkc_pkg::CIDX_W-1:0] coef_rd_addr, scl_rd_addr;
  logic                       scl_we;
  logic [15:0]                scl_wdata;
  logic                       last_idx;
  logic                       sum_big;
  logic signed [24:0]         prod;
  logic signed [24:0]         prod_t;
  logic [15:0]                mag;
  logic [23:0]                q_s;

  assign w_sat    = (image_width == 9'd0) ? 9'd1 :
                    (image_width > 9'(wkc_pkg::MAX_WIDTH)) ? 9'(wkc_pkg::MAX_WIDTH) :
                    image_width;
  assign h_sat    = (image_height == 9'd0) ? 9'd1 :
                    (image_height > 9'(wkc_pkg::MAX_HEIGHT)) ? 9'(wkc_pkg::MAX_HEIGHT) :
                    image_height;
  assign k_sat    = (kern_side == 3'd0) ? 3'd1 : kern_side;
  assign taps_sat = 6'(k_sat) * 6'(k_sat);

  assign coef_val = coef_rd_vld ? $signed(coef_rd) : 16'sd0;
  assign scl_val  = scl_rd_vld ? $signed(scl_rd) : 16'sd0;
  assign last_idx = (idx == wkc_pkg::CIDX_W'(wkc_pkg::NCOEF - 1));
  assign sum_big  = sum > 22'sd256;
  assign mag      = coef_val[15] ? 16'(-coef_val) : coef_val;
  assign q_s      = neg_q ? (24'd0 - div_rsp.quot) : div_rsp.quot;

  assign prod   = $signed({17'd0, frame_rd}) * 25'(scl_val);
  assign prod_t = prod[24] ? ((prod + 25'sd255) >>> 8) : (prod >>> 8);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wkc_pkg::ST_IDLE:
        if (in_acc && func == wkc_pkg::FUNC_COMPUTE) begin
          state_next = coef_stale ? wkc_pkg::ST_SUM_RD : wkc_pkg::ST_MODR;
        end
      wkc_pkg::ST_SUM_RD:  state_next = wkc_pkg::ST_SUM_ACC;
      wkc_pkg::ST_SUM_ACC:
        state_next = (6'(idx) == last_q) ? wkc_pkg::ST_SC_RD : wkc_pkg::ST_SUM_RD;
      wkc_pkg::ST_SC_RD:   state_next = wkc_pkg::ST_SC_DIV;
      wkc_pkg::ST_SC_DIV:
        if (sum_big) begin
          state_next = wkc_pkg::ST_SC_WAIT;
        end else begin
          state_next = last_idx ? wkc_pkg::ST_MODR : wkc_pkg::ST_SC_RD;
        end
      wkc_pkg::ST_SC_WAIT:
        if (div_rsp.done) begin
          state_next = last_idx ? wkc_pkg::ST_MODR : wkc_pkg::ST_SC_RD;
        end
      wkc_pkg::ST_MODR:    state_next = wkc_pkg::ST_MODR_W;
      wkc_pkg::ST_MODR_W:  if (div_rsp.done) state_next = wkc_pkg::ST_MODC;
      wkc_pkg::ST_MODC:    state_next = wkc_pkg::ST_MODC_W;
      wkc_pkg::ST_MODC_W:  if (div_rsp.done) state_next = wkc_pkg::ST_WRAPR;
      wkc_pkg::ST_WRAPR:   if (!rr[9]) state_next = wkc_pkg::ST_WRAPC;
      wkc_pkg::ST_WRAPC:   if (!cc[9]) state_next = wkc_pkg::ST_TAP_RD;
      wkc_pkg::ST_TAP_RD:  state_next = wkc_pkg::ST_TAP_MAC;
      wkc_pkg::ST_TAP_MAC:
        state_next = (idx == '0) ? wkc_pkg::ST_DONE : wkc_pkg::ST_TAP_RD;
      wkc_pkg::ST_DONE:
        if (!m_tvalid || m_tready) state_next = wkc_pkg::ST_IDLE;
      default:             state_next = wkc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    coef_rd_en       = 1'b0;
    scl_rd_en        = 1'b0;
    frame_rd_en      = 1'b0;
    coef_rd_addr     = idx;
    scl_rd_addr      = idx;
    scl_we           = 1'b0;
    scl_wdata        = coef_val;
    div_req.start    = 1'b0;
    div_req.dividend = {mag, 8'h00};
    div_req.divisor  = sum;
    case (state)
      wkc_pkg::ST_SUM_RD: coef_rd_en = 1'b1;
      wkc_pkg::ST_SC_RD:  coef_rd_en = 1'b1;
      wkc_pkg::ST_SC_DIV: begin
        div_req.start = sum_big;
        scl_we        = !sum_big;
      end
      wkc_pkg::ST_SC_WAIT: begin
        scl_we    = div_rsp.done;
        scl_wdata = q_s[15:0];
      end
      wkc_pkg::ST_MODR: begin
        div_req.start    = 1'b1;
        div_req.dividend = 24'(row_q);
        div_req.divisor  = 22'(h_q);
      end
      wkc_pkg::ST_MODC: begin
        div_req.start    = 1'b1;
        div_req.dividend = 24'(col_q);
        div_req.divisor  = 22'(w_q);
      end
      wkc_pkg::ST_TAP_RD: begin
        scl_rd_en   = 1'b1;
        frame_rd_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wkc_pkg::ST_IDLE;
      image_width  <= 9'(wkc_pkg::MAX_WIDTH);
      image_height <= 9'(wkc_pkg::MAX_HEIGHT);
      kern_side    <= 3'd3;
      coef_stale   <= 1'b1;
      coef_vld     <= '0;
      scl_vld      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wkc_pkg::REG_WIDTH:  image_width  <= cfg_data;
          wkc_pkg::REG_HEIGHT: image_height <= cfg_data;
          wkc_pkg::REG_KSIZE:  kern_side    <= cfg_data[2:0];
          default: ;
        endcase
      end
      if ((cfg_valid && cfg_ready && cfg_index == wkc_pkg::REG_KSIZE) || coef_ld) begin
        coef_stale <= 1'b1;
      end else if (scl_we && last_idx) begin
        coef_stale <= 1'b0;
      end
      if (coef_ld) coef_vld[in_cidx[wkc_pkg::CIDX_W-1:0]] <= 1'b1;
      if (scl_we) scl_vld[idx] <= 1'b1;
      if (state == wkc_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_acc && func == wkc_pkg::FUNC_PIXEL) begin
      frame_mem[{in_row, in_col}] <= in_val[7:0];
    end
    if (frame_rd_en) begin
      frame_rd <= frame_mem[{rr[wkc_pkg::ROWB-1:0], cc[wkc_pkg::COLB-1:0]}];
    end
    if (coef_ld) begin
      coef_mem[in_cidx[wkc_pkg::CIDX_W-1:0]] <= in_val;
    end
    if (coef_rd_en) begin
      coef_rd     <= coef_mem[coef_rd_addr];
      coef_rd_vld <= coef_vld[coef_rd_addr];
    end
    if (scl_we) scl_mem[idx] <= scl_wdata;
    if (scl_rd_en) begin
      scl_rd     <= scl_mem[scl_rd_addr];
      scl_rd_vld <= scl_vld[scl_rd_addr];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      wkc_pkg::ST_IDLE: begin
        row_q  <= in_row;
        col_q  <= in_col;
        w_q    <= w_sat;
        h_q    <= h_sat;
        k_q    <= k_sat;
        half_q <= 2'((k_sat - 3'd1) >> 1);
        last_q <= taps_sat - 6'd1;
        idx    <= '0;
        sum    <= '0;
      end
      wkc_pkg::ST_SUM_ACC: begin
        sum <= sum + 22'(coef_val);
        idx <= (6'(idx) == last_q) ? '0 : idx + 1'b1;
      end
      wkc_pkg::ST_SC_DIV: begin
        neg_q <= coef_val[15];
        if (!sum_big) idx <= idx + 1'b1;
      end
      wkc_pkg::ST_SC_WAIT:
        if (div_rsp.done) idx <= idx + 1'b1;
      wkc_pkg::ST_MODR_W:
        if (div_rsp.done) rr <= $signed({1'b0, div_rsp.rem[8:0]}) - 10'(half_q);
      wkc_pkg::ST_MODC_W:
        if (div_rsp.done) cc <= $signed({1'b0, div_rsp.rem[8:0]}) - 10'(half_q);
      wkc_pkg::ST_WRAPR:
        if (rr[9]) rr <= rr + $signed({1'b0, h_q});
      wkc_pkg::ST_WRAPC: begin
        if (cc[9]) cc <= cc + $signed({1'b0, w_q});
        else c_start <= cc;
        idx <= last_q[wkc_pkg::CIDX_W-1:0];
        kr  <= '0;
        kc  <= '0;
        acc <= '0;
      end
      wkc_pkg::ST_TAP_MAC: begin
        acc <= acc + prod_t[7:0];
        idx <= idx - 1'b1;
        if (kc == k_q - 3'd1) begin
          kc <= '0;
          kr <= kr + 3'd1;
          cc <= c_start;
          rr <= (rr + 10'sd1 == $signed({1'b0, h_q})) ? 10'sd0 : rr + 10'sd1;
        end else begin
          kc <= kc + 3'd1;
          cc <= (cc + 10'sd1 == $signed({1'b0, w_q})) ? 10'sd0 : cc + 10'sd1;
        end
      end
      wkc_pkg::ST_DONE:
        if (!m_tvalid || m_tready) m_tdata <= {col_q, row_q, acc};
      default: ;
    endcase
  end

  wkc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  `WKC_ASSERT_NOW(a_div_idle_start, div_req.start, !div_rsp.busy, "divider started while busy")
  `WKC_ASSERT_NOW(a_fresh_coef, state == wkc_pkg::ST_MODR, !coef_stale,
                  "compute without fresh scaled coefficients")
  `WKC_ASSERT_NOW(a_tap_in_image, state == wkc_pkg::ST_TAP_RD,
                  !rr[9] && !cc[9] && rr < $signed({1'b0, h_q}) && cc < $signed({1'b0, w_q}),
                  "tap address outside image")
  `WKC_ASSERT_NEXT(a_done_out, state == wkc_pkg::ST_DONE && state_next == wkc_pkg::ST_IDLE,
                   m_tvalid, "finished pixel not presented")

endmodule

`default_nettype wire
